// ----- hw/rtl/psk_pkg.sv -----
// ----------------------------------------------------------------------------
// psk_pkg
// Shared types, sizes and codes of the partitioned multi-stack core.
// ----------------------------------------------------------------------------
package psk_pkg;

    // Shared memory depth and the largest number of stacks.
    localparam int DEPTH      = 64;
    localparam int MAX_STACKS = 16;
    // Usable stack count: a partition holds at least one word.
    localparam int MAX_N      = (MAX_STACKS < DEPTH) ? MAX_STACKS : DEPTH;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int SNO_W   = 4;
    localparam int SIDX_W  = $clog2(MAX_STACKS);
    localparam int CFG_W   = 5;
    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 3;

    // Command queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register byte address bits and index.
    localparam int PADDR_W = 3;
    localparam logic REG_NUM_STACKS = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_DUMP = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_BADSTACK  = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // One classified request as the front hands it to the back.
    typedef struct packed {
        op_t                op;
        logic [SIDX_W-1:0]  stack_idx;
        logic [DATA_W-1:0]  data;
        logic               bad;
        logic [ADDR_W-1:0]  base;
        logic [FILL_W-1:0]  size;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_req_t;

endpackage

// ----- hw/rtl/psk_front.sv -----
// ----------------------------------------------------------------------------
// psk_front
// Decodes a request: effective stack count, partition size and base address,
// and the stack number range check.
// ----------------------------------------------------------------------------
module psk_front import psk_pkg::*; (
    input  logic [CFG_W-1:0]  num_stacks,
    input  logic              in_valid,
    input  logic [FUNC_W-1:0] in_func,
    input  logic [SNO_W-1:0]  in_stack_no,
    input  logic [DATA_W-1:0] in_data,
    output cmd_req_t          req
);

    localparam logic [CFG_W-1:0] MAX_N_V = CFG_W'(MAX_N);

    logic [FILL_W-1:0]        size_tab [MAX_N+1];
    logic [CFG_W-1:0]         n_eff;
    logic [FILL_W-1:0]        size;
    logic [SNO_W+FILL_W-1:0]  base_full;

    // Partition size for every stack count, settled at elaboration.
    assign size_tab[0] = FILL_W'(DEPTH);
    for (genvar g = 1; g <= MAX_N; g++) begin : g_size
        localparam int PART = DEPTH / g;
        assign size_tab[g] = FILL_W'(PART);
    end

    always_comb begin
        if (num_stacks == '0) begin
            n_eff = CFG_W'(1);
        end else if (num_stacks > MAX_N_V) begin
            n_eff = MAX_N_V;
        end else begin
            n_eff = num_stacks;
        end
    end

    assign size      = size_tab[n_eff];
    assign base_full = in_stack_no * size;

    always_comb begin
        req.valid         = in_valid && (op_t'(in_func) != OP_NONE);
        req.cmd.op        = op_t'(in_func);
        req.cmd.stack_idx = in_stack_no[SIDX_W-1:0];
        req.cmd.data      = in_data;
        req.cmd.bad       = {{(CFG_W-SNO_W){1'b0}}, in_stack_no} >= n_eff;
        req.cmd.base      = base_full[ADDR_W-1:0];
        req.cmd.size      = size;
    end

endmodule

// ----- hw/rtl/psk_queue.sv -----
// ----------------------------------------------------------------------------
// psk_queue
// Short command queue that lets the front and the back stall separately.
// ----------------------------------------------------------------------------
module psk_queue import psk_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cmd_req_t push,
    output logic     full,
    input  logic     pop,
    output cmd_req_t head
);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign do_push  = push.valid && !full;
    assign do_pop   = pop && (count_reg != '0);
    assign head.valid = count_reg != '0;
    assign head.cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

// ----- hw/rtl/psk_back.sv -----
// ----------------------------------------------------------------------------
// psk_back
// Executes queued requests against the fill counts and the shared stack
// memory, and drives the result register.
// ----------------------------------------------------------------------------
module psk_back import psk_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clear_fill,
    input  cmd_req_t           head,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [STAT_W-1:0]  res_status,
    output logic [DATA_W-1:0]  res_value,
    output logic               res_last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [FILL_W-1:0]    fill_reg [MAX_STACKS];
    logic [FILL_W-1:0]    fill_cur;
    logic [FILL_W-1:0]    idx_reg, idx_next;
    logic [FILL_W-1:0]    dump_cnt_reg;
    logic                 is_dump_reg;
    logic [DATA_W-1:0]    mem [DEPTH];
    logic [DATA_W-1:0]    rdata_reg;
    logic                 rd_en, wr_en;
    logic [FILL_W-1:0]    rd_off;
    logic [FILL_W:0]      rd_sum, wr_sum;
    logic [ADDR_W-1:0]    rd_addr, wr_addr;
    logic [STAT_W-1:0]    status_reg;
    logic [DATA_W-1:0]    value_reg;
    logic                 last_reg;
    logic                 dump_more;

    // Fill counts never pass the partition size, the clamp keeps it certain.
    always_comb begin
        fill_cur = fill_reg[cmd_reg.stack_idx];
        if (fill_cur > cmd_reg.size) begin
            fill_cur = cmd_reg.size;
        end
    end

    assign dump_more = is_dump_reg && !last_reg;

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        rd_off     = '0;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (head.valid) begin
                    pop        = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_OUT;
                if (!cmd_reg.bad) begin
                    case (cmd_reg.op)
                        OP_PUSH: begin
                            wr_en = fill_cur < cmd_reg.size;
                        end
                        OP_POP: begin
                            if (fill_cur != '0) begin
                                rd_en      = 1'b1;
                                rd_off     = fill_cur - 1'b1;
                                state_next = S_READ;
                            end
                        end
                        OP_DUMP: begin
                            if (fill_cur != '0) begin
                                rd_en      = 1'b1;
                                idx_next   = '0;
                                state_next = S_READ;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (res_ready) begin
                    if (dump_more) begin
                        idx_next   = idx_reg + 1'b1;
                        rd_en      = 1'b1;
                        rd_off     = idx_reg + 1'b1;
                        state_next = S_READ;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_sum  = {1'b0, FILL_W'(cmd_reg.base)} + {1'b0, rd_off};
    assign wr_sum  = {1'b0, FILL_W'(cmd_reg.base)} + {1'b0, fill_cur};
    assign rd_addr = rd_sum[ADDR_W-1:0];
    assign wr_addr = wr_sum[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int i = 0; i < MAX_STACKS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (clear_fill) begin
                for (int i = 0; i < MAX_STACKS; i++) begin
                    fill_reg[i] <= '0;
                end
            end else if (wr_en) begin
                fill_reg[cmd_reg.stack_idx] <= fill_cur + 1'b1;
            end else if (state_reg == S_EXEC && cmd_reg.op == OP_POP && !cmd_reg.bad
                         && fill_cur != '0) begin
                fill_reg[cmd_reg.stack_idx] <= fill_cur - 1'b1;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= head.cmd;
        end
        idx_reg <= idx_next;
        if (state_reg == S_EXEC) begin
            dump_cnt_reg <= fill_cur;
            is_dump_reg  <= cmd_reg.op == OP_DUMP && !cmd_reg.bad;
            value_reg    <= '0;
            last_reg     <= 1'b1;
            if (cmd_reg.bad) begin
                status_reg <= ST_BADSTACK;
            end else begin
                case (cmd_reg.op)
                    OP_PUSH: begin
                        if (fill_cur < cmd_reg.size) begin
                            status_reg <= ST_OK;
                            value_reg  <= cmd_reg.data;
                        end else begin
                            status_reg <= ST_OVERFLOW;
                        end
                    end
                    OP_POP: begin
                        status_reg <= (fill_cur != '0) ? ST_OK : ST_UNDERFLOW;
                    end
                    default: begin
                        status_reg <= (fill_cur != '0) ? ST_OK : ST_EMPTY;
                    end
                endcase
            end
        end else if (state_reg == S_READ) begin
            value_reg <= rdata_reg;
            last_reg  <= !is_dump_reg || (idx_reg + 1'b1 == dump_cnt_reg);
        end
    end

    // Shared stack memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= cmd_reg.data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign res_valid  = state_reg == S_OUT;
    assign res_status = status_reg;
    assign res_value  = value_reg;
    assign res_last   = last_reg;

endmodule

// ----- hw/rtl/partitioned_multi_stack_core.sv -----
// ----------------------------------------------------------------------------
// partitioned_multi_stack_core
// Several stacks sharing one memory split into equal partitions.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  tuser: func; tdata: stack_no, data
//  m_        out        m_tvalid/m_tready  tuser: status; tdata: value; tlast
//  APB       in         psel/penable       register num_stacks at byte 0
//
//  A push, an overflow, an underflow, a dump of an empty stack or a bad stack
//  number goes through the execution unit states dequeue, execute and
//  present; a pop also waits on the registered memory read. A dump reads
//  and presents each entry in turn through the single read port.
//  Reset clears the fill counts and sets num_stacks to 1; the memory contents
//  are not cleared and need no clearing pass. The input side keeps accepting
//  requests into a two-entry queue while a result waits on m_tready.
//
module partitioned_multi_stack_core import psk_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // Input request stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,   // [3:0] stack_no, [35:4] data, rest zero
    input  logic [7:0]          s_tuser,   // [1:0] func, rest zero
    // Result stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // [31:0] value
    output logic [7:0]          m_tuser,   // [2:0] status, rest zero
    output logic                m_tlast,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [CFG_W-1:0]   num_stacks_reg;
    logic               cfg_write;
    cmd_req_t           front_req;
    cmd_req_t           queue_head;
    logic               queue_full;
    logic               queue_pop;
    logic [STAT_W-1:0]  res_status;

    // The register lives at byte address 0; bit 2 selects the register slot.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_NUM_STACKS);
    assign prdata    = (paddr[2] == REG_NUM_STACKS) ?
                       {{(32-CFG_W){1'b0}}, num_stacks_reg} : '0;

    // Every write to num_stacks repartitions the memory, so all stacks empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_stacks_reg <= CFG_W'(1);
        end else if (cfg_write) begin
            num_stacks_reg <= pwdata[CFG_W-1:0];
        end
    end

    // The front takes a request whenever the queue has room. An unused
    // opcode is accepted and dropped there.
    assign s_tready = !queue_full;

    psk_front u_front (
        .num_stacks  (num_stacks_reg),
        .in_valid    (s_tvalid && s_tready),
        .in_func     (s_tuser[FUNC_W-1:0]),
        .in_stack_no (s_tdata[SNO_W-1:0]),
        .in_data     (s_tdata[SNO_W+DATA_W-1:SNO_W]),
        .req         (front_req)
    );

    psk_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (front_req),
        .full    (queue_full),
        .pop     (queue_pop),
        .head    (queue_head)
    );

    psk_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear_fill (cfg_write),
        .head       (queue_head),
        .pop        (queue_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (res_status),
        .res_value  (m_tdata),
        .res_last   (m_tlast)
    );

    assign m_tuser = {{(8-STAT_W){1'b0}}, res_status};

endmodule

// ----- hw/rtl/psk_checker.sv -----
// ----------------------------------------------------------------------------
// psk_checker
// Port-level checks of the partitioned multi-stack core, bound to the top.
// ----------------------------------------------------------------------------
module psk_checker import psk_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [7:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // Error and empty results end the request's output.
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[STAT_W-1:0] != ST_OK |-> m_tlast)
        else $error("non-ok result without last");

    // Error and empty results carry a zero value.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[STAT_W-1:0] != ST_OK |-> m_tdata == '0)
        else $error("non-ok result with nonzero value");

    // Status stays within the defined codes and upper tuser bits stay clear.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[7:STAT_W] == '0 && m_tuser[STAT_W-1:0] <= ST_EMPTY)
        else $error("undefined status code");

endmodule

bind partitioned_multi_stack_core psk_checker u_psk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for partitioned_multi_stack_core. A clocked driver
// streams push, pop and dump requests from a queue and a clocked monitor
// checks every result against a predictor of the partitioned stacks. The
// stack count register is rewritten between phases over APB.
// ----------------------------------------------------------------------------
module tb import psk_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    // Cycles allowed with no handshake of any kind before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    // Quiet cycles after the last result, enough for requests that give no result.
    localparam int SETTLE_CYCLES  = 20;
    // Length of the deliberate receiver hold-off that backs the block up.
    localparam int LONG_HOLD      = 300;

    // One request as the driver sends it.
    typedef struct packed {
        op_t               op;
        logic [SNO_W-1:0]  sno;
        logic [DATA_W-1:0] data;
    } stack_req_t;

    // One result as the block should return it.
    typedef struct {
        status_t           status;
        logic [DATA_W-1:0] value;
        logic              last;
    } stack_result_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [39:0]         s_tdata  = '0;
    logic [7:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;
    logic [7:0]          m_tuser;
    logic                m_tlast;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    partitioned_multi_stack_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor state: its own copy of the memory, the fill counts and the
    // stack count register.
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0] model_mem  [DEPTH];
    logic [FILL_W-1:0] model_fill [MAX_STACKS];
    logic [CFG_W-1:0]  model_num_stacks = CFG_W'(1);

    stack_req_t    requests_to_send[$];
    stack_result_t results_due[$];

    int  errors       = 0;
    int  src_idle_pct = 0;
    int  rx_stall_pct = 0;
    int  hold_asked   = 0;
    int  hold_granted = 0;
    int  hold_left    = 0;
    int  quiet_cycles = 0;
    logic s_acc = 1'b0;

    // The register value as the block uses it: zero acts as one, and the
    // count is capped by the number of stacks and by the memory depth.
    function automatic int effective_stacks();
        int n;
        n = int'(model_num_stacks);
        if (n == 0) n = 1;
        if (n > MAX_STACKS) n = MAX_STACKS;
        if (n > DEPTH) n = DEPTH;
        return n;
    endfunction

    function automatic void queue_result(status_t st, logic [DATA_W-1:0] v, logic l);
        stack_result_t r;
        r.status = st;
        r.value  = v;
        r.last   = l;
        results_due.push_back(r);
    endfunction

    // Work out what one accepted request does to the stacks and what it returns.
    function automatic void apply_request(op_t op, logic [SNO_W-1:0] sno,
                                          logic [DATA_W-1:0] d);
        int n;
        int size;
        int base;
        int fill;
        n    = effective_stacks();
        size = DEPTH / n;
        if (op == OP_NONE) return;
        // A stack number past the partitions in use touches nothing.
        if (int'(sno) >= n) begin
            queue_result(ST_BADSTACK, '0, 1'b1);
            return;
        end
        base = int'(sno) * size;
        fill = int'(model_fill[sno]);
        if (fill > size) fill = size;
        case (op)
            OP_PUSH: begin
                if (fill >= size) begin
                    queue_result(ST_OVERFLOW, '0, 1'b1);
                end else begin
                    model_mem[(base + fill) % DEPTH] = d;
                    model_fill[sno] = FILL_W'(fill + 1);
                    queue_result(ST_OK, d, 1'b1);
                end
            end
            OP_POP: begin
                if (fill == 0) begin
                    queue_result(ST_UNDERFLOW, '0, 1'b1);
                end else begin
                    fill = fill - 1;
                    model_fill[sno] = FILL_W'(fill);
                    queue_result(ST_OK, model_mem[(base + fill) % DEPTH], 1'b1);
                end
            end
            default: begin
                // Dump walks bottom to top; only the top entry carries last.
                if (fill == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < fill; i++) begin
                        queue_result(ST_OK, model_mem[(base + i) % DEPTH], i + 1 == fill);
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents requests at the falling edge. A new request is only
    // put up once the previous one was taken at the rising edge before, and
    // each signal gets a single assignment per edge.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        stack_req_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_acc) begin
            if (requests_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                req = requests_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, req.data, req.sno};
                s_tuser  <= {6'b0, req.op};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is asked for.
    // The hold is counted here so that it runs while the sender keeps going.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_granted != hold_asked) begin
            hold_granted <= hold_asked;
            hold_left    <= LONG_HOLD;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Predictor and monitor, both on the rising edge. An accepted request is
    // predicted at once; an accepted result is checked against the oldest
    // outstanding expectation. The block's latency keeps the two apart.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        stack_result_t want;
        s_acc <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            apply_request(op_t'(s_tuser[FUNC_W-1:0]), s_tdata[SNO_W-1:0],
                          s_tdata[SNO_W +: DATA_W]);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: result with none outstanding:", $time,
                         " status=%0d value=%h last=%0d", m_tuser, m_tdata, m_tlast);
            end else begin
                want = results_due.pop_front();
                if (m_tuser !== {5'b0, want.status} || m_tdata !== want.value ||
                    m_tlast !== want.last) begin
                    errors++;
                    $display("%0t: result mismatch:", $time,
                             " expected status=%0d value=%h last=%0d,",
                             want.status, want.value, want.last,
                             " got status=%0d value=%h last=%0d",
                             m_tuser, m_tdata, m_tlast);
                end
            end
        end
    end

    // Watchdog: any handshake on any port counts as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, results_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic void add_request(op_t op, int sno, logic [DATA_W-1:0] d);
        stack_req_t req;
        req.op   = op;
        req.sno  = SNO_W'(sno);
        req.data = d;
        requests_to_send.push_back(req);
    endfunction

    // Mostly random words, with the extremes mixed in often.
    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Length of a push or pop run: past the partition size when partitions
    // are small, and only now and then when they are large.
    function automatic int run_length(int size);
        if (size <= 8 || $urandom_range(5) == 0) return size + 1;
        return $urandom_range(8, 1);
    endfunction

    // Random part of a phase. Most of it is runs that push onto one stack,
    // dump it and pop it, past overflow and underflow when partitions are
    // small; the rest is single requests, bad stack numbers and the unused opcode.
    task automatic queue_random_requests(input int count);
        int n;
        int size;
        int sent;
        int k;
        int s;
        int r;
        n    = effective_stacks();
        size = DEPTH / n;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(99);
            s = $urandom_range(n - 1);
            if (r < 25) begin
                k = run_length(size);
                repeat (k) add_request(OP_PUSH, s, pick_data());
                add_request(OP_DUMP, s, $urandom());
                sent += k + 1;
                k = run_length(size);
                repeat (k) add_request(OP_POP, s, $urandom());
                sent += k;
            end else if (r < 58) begin
                add_request(OP_PUSH, s, pick_data());
                sent++;
            end else if (r < 80) begin
                add_request(OP_POP, s, $urandom());
                sent++;
            end else if (r < 90) begin
                add_request(OP_DUMP, s, $urandom());
                sent++;
            end else if (r < 96) begin
                if (n < MAX_STACKS) begin
                    add_request(OP_PUSH, $urandom_range(MAX_STACKS - 1, n), $urandom());
                end else begin
                    add_request(OP_POP, s, $urandom());
                end
                sent++;
            end else begin
                // The unused opcode is ignored by the block and is not counted.
                add_request(OP_NONE, $urandom_range(MAX_STACKS - 1), $urandom());
            end
        end
    endtask

    // Wait until every request went out and every result came back, then
    // let the block settle so that no ignored request is still in flight.
    task automatic wait_for_idle();
        while (requests_to_send.size() != 0 || s_tvalid) @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write of num_stacks followed by a read back. The write lands at the
    // rising edge of the access cycle, which is where the predictor follows.
    task automatic write_num_stacks(input logic [31:0] val);
        logic [31:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({REG_NUM_STACKS, 2'b00});
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // Any write empties every stack; the memory itself is kept.
        model_num_stacks = val[CFG_W-1:0];
        for (int i = 0; i < MAX_STACKS; i++) model_fill[i] = '0;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        psel    <= 1'b1;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        if (got !== {27'b0, val[CFG_W-1:0]}) begin
            errors++;
            $display("%0t: num_stacks read back: expected %h, got %h",
                     $time, {27'b0, val[CFG_W-1:0]}, got);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // One random phase: new stack count, new idling mix, then drain.
    task automatic run_phase(input logic [31:0] cfg, input int src_pct, input int rx_pct,
                             input bit long_hold, input int count);
        write_num_stacks(cfg);
        src_idle_pct <= src_pct;
        rx_stall_pct <= rx_pct;
        if (long_hold) hold_asked <= hold_asked + 1;
        queue_random_requests(count);
        wait_for_idle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset setting of one stack over the whole memory:
        // pop and dump of an empty stack, a bad stack number, the unused opcode,
        // and the data extremes pushed, dumped and popped.
        add_request(OP_POP,  0, 32'h0000_0000);
        add_request(OP_DUMP, 0, 32'hffff_ffff);
        add_request(OP_PUSH, 1, 32'h1234_5678);
        add_request(OP_NONE, 0, 32'hffff_ffff);
        add_request(OP_PUSH, 0, 32'h7fff_ffff);
        add_request(OP_PUSH, 0, 32'h8000_0000);
        add_request(OP_DUMP, 0, 32'h0000_0000);
        add_request(OP_POP,  0, 32'h0000_0000);
        wait_for_idle();

        // Sixteen stacks of four words: fill the top stack past overflow,
        // dump it, pop it, and hit an empty neighbor.
        write_num_stacks(32'd16);
        add_request(OP_PUSH, 15, 32'hffff_ffff);
        add_request(OP_PUSH, 15, 32'h0000_0000);
        add_request(OP_PUSH, 15, 32'h7fff_ffff);
        add_request(OP_PUSH, 15, 32'h8000_0000);
        add_request(OP_PUSH, 15, 32'h5555_aaaa);
        add_request(OP_DUMP, 15, 32'h0000_0000);
        add_request(OP_POP,  15, 32'h0000_0000);
        add_request(OP_POP,  0,  32'h0000_0000);
        add_request(OP_PUSH, 0,  32'haaaa_5555);
        wait_for_idle();

        // A value above the stack limit acts as the limit, and the write
        // empties the stacks: the top stack dumps and pops as empty.
        write_num_stacks(32'd31);
        add_request(OP_DUMP, 15, 32'h0000_0000);
        add_request(OP_POP,  15, 32'h0000_0000);
        add_request(OP_PUSH, 15, 32'h0000_0001);
        wait_for_idle();

        // Zero acts as one stack, so stack fifteen is now a bad number.
        write_num_stacks(32'd0);
        add_request(OP_PUSH, 15, 32'hdead_beef);
        add_request(OP_POP,  0,  32'h0000_0000);
        add_request(OP_PUSH, 0,  32'hc001_d00d);
        add_request(OP_POP,  0,  32'h0000_0000);
        add_request(OP_NONE, 15, 32'hffff_ffff);
        wait_for_idle();

        // Random phases over several stack counts and idling mixes. The phase
        // with the long hold-off backs the block up until it stops taking
        // requests; every phase ends with the sender waiting for all results.
        run_phase(32'd3,  0,  0,  1'b0, 45);
        run_phase(32'd16, 62, 0,  1'b0, 45);
        run_phase(32'd1,  0,  62, 1'b0, 45);
        run_phase(32'd31, 27, 27, 1'b0, 45);
        run_phase(32'd0,  0,  0,  1'b1, 45);
        run_phase(32'd5,  0,  0,  1'b0, 45);
        run_phase(32'd7,  27, 27, 1'b0, 45);

        if (results_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, results_due.size());
        end
        if (errors == 0 && results_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
